[hdl/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/deq_pkg.sv]
// types and constants of the double-ended queue
package deq_pkg;

   // depth must be a power of two, slots wrap by dropping carry bits
   localparam int DEPTH   = 256;
   localparam int ELEM_W  = 32;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = 8;
   localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK   = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;

   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         index;
   } deq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [8:0]               count;
      logic                     is_empty;
      logic                     error;
      logic                     overflow;
   } deq_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_RESULT
   } deq_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } deq_cmd_type;

endpackage

[hdl/double_ended_queue.sv]
// double-ended queue: top level
//
// A request word (push back, push front, pop back, pop front, read at index)
// is taken when start is high and busy is low. Each request gives exactly one
// result word on rsp_word, shown for one cycle with rsp_strobe high; the
// receiver cannot hold it off.
// Timing: the request is latched at the accept edge, the element store is
// written or read in the access state, and the result shows in the result
// state that follows, with rsp_strobe high. busy is high in both of these
// states, and a new request can be taken in the cycle after the strobe, not
// before; the pace is set by the registered read of the store.
// Pops on an empty queue and reads at or past the count return 0 with error
// set; a push onto a full store is dropped with overflow set. Every result
// carries the count and the empty flag after the request.
// Reset empties the queue at once (head and count cleared); the store itself
// is not cleared, since only slots written by a push are ever read.
`include "assert_macros.svh"
module double_ended_queue import deq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  deq_req_type req_word,
   output logic        rsp_strobe,
   output deq_rsp_type rsp_word
);

   deq_cmd_type cmd;

   deq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .cmd       (cmd)
   );

   deq_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_word(req_word),
      .rsp_word(rsp_word)
   );

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe && !busy)
   `ASSERT_IMPLIES(a_empty_flag, clock, reset, rsp_strobe, rsp_word.is_empty == (rsp_word.count == '0))
   `ASSERT_IMPLIES(a_flags_excl, clock, reset, rsp_strobe, !(rsp_word.error && rsp_word.overflow))
   `ASSERT_IMPLIES(a_count_max, clock, reset, rsp_strobe, rsp_word.count <= 9'(DEPTH))

endmodule

[hdl/deq_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/deq_datapath.sv]
// ring buffer pointers, element store and result formatting
module deq_datapath import deq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  deq_cmd_type cmd,
   input  deq_req_type req_word,
   output deq_rsp_type rsp_word
);

   deq_req_type         req_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic                err_ff, err_in;
   logic                ovf_ff, ovf_in;
   logic                rd_ok_ff, rd_ok_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ELEM_W-1:0]   rd_data;
   logic                full;
   logic                empty;
   logic [ADDR_W-1:0]   cnt_lo;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign cnt_lo = count_ff[ADDR_W-1:0];

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      err_in   = 1'b0;
      ovf_in   = 1'b0;
      rd_ok_in = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = head_ff + cnt_lo;
      rd_addr  = head_ff;
      case (req_ff.req_type)
         OP_PUSH_BACK: begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            wr_addr = head_ff - 1'b1;
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               head_in  = head_ff - 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_BACK: begin
            rd_addr = head_ff + cnt_lo - 1'b1;
            if (empty) begin
               err_in = 1'b1;
            end else begin
               rd_ok_in = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               rd_ok_in = 1'b1;
               head_in  = head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            rd_addr = head_ff + ADDR_W'(req_ff.index);
            if (CMP_W'(req_ff.index) >= CMP_W'(count_ff)) begin
               err_in = 1'b1;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.exec) begin
         err_ff   <= err_in;
         ovf_ff   <= ovf_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   deq_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.exec && wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_ff.value[ELEM_W-1:0]),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // read data is registered at the end of the access state and valid in the result state
   always_comb begin
      rsp_word.data     = rd_ok_ff ? DATA_W'(signed'(rd_data)) : '0;
      rsp_word.count    = 9'(count_ff);
      rsp_word.is_empty = empty;
      rsp_word.error    = err_ff;
      rsp_word.overflow = ovf_ff;
   end

endmodule

[hdl/deq_controller.sv]
// sequencer for one request: latch, store access, result
module deq_controller import deq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   output deq_cmd_type cmd
);

   deq_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: state_in = ST_RESULT;
         ST_RESULT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load    = 1'b0;
      cmd.exec    = 1'b0;
      cmd.respond = 1'b0;
      busy        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_ACCESS: cmd.exec    = 1'b1;
         ST_RESULT: cmd.respond = 1'b1;
         default:   busy        = 1'b1;
      endcase
   end

   assign rsp_strobe = cmd.respond;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
